// File: hw/rtl/hfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfe_pkg
// Types, constants and helpers shared by the frame encoder modules.
// ----------------------------------------------------------------------------
package hfe_pkg;

  localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
  localparam logic [7:0]  ESC_BYTE    = 8'h7D;
  localparam logic [7:0]  ESC_XOR     = 8'h20;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CONST_CHECK = 16'hD00B;

  localparam logic [1:0] MODE_CONST = 2'd0;
  localparam logic [1:0] MODE_CRC   = 2'd1;
  localparam logic [1:0] MODE_SUM   = 2'd2;

  // one queued job: a frame start or one payload byte
  typedef struct packed {
    logic        is_start;
    logic        close;     // check and closing flag follow this job
    logic [15:0] w0;        // command, or payload byte in the low bits
    logic [15:0] w1;        // payload length
  } job_t;

  typedef enum logic [3:0] {
    SL_FLAG,
    SL_CMD_HI,
    SL_CMD_LO,
    SL_LEN_HI,
    SL_LEN_LO,
    SL_DATA,
    SL_CALC1,
    SL_CALC2,
    SL_CHK_HI,
    SL_CHK_LO,
    SL_END
  } slot_t;

  // crc-16, msb first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/hdlc_frame_encoder_crc16_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_frame_encoder_crc16_top
// Byte-stuffed frame encoder with selectable 16-bit check.
//
//   channel   dir  handshake               payload
//   s_axis    in   s_axis_tvalid/tready    tdata {data_byte, length, command}, tuser opcode
//   m_axis    out  m_axis_tvalid/tready    tdata out_byte, tlast frame_end
//   cfg       in   cfg_we                  cfg_wdata check_mode
//
// The output moves one byte per cycle unless m_axis_tready stalls it, no job is queued or the
// check is being calculated; a payload request yields one byte, two when its byte is escaped.
// A frame start yields five to nine bytes, and a closing frame adds three to five bytes.
// Requests are taken while the job queue (QUEUE_DEPTH entries) has room.
// Reset (rst, synchronous) empties the queue and drops any open frame.
// ----------------------------------------------------------------------------
module hdlc_frame_encoder_crc16_top import hfe_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // command[15:0], payload_length[31:16], data_byte[39:32]
  input  logic        s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  logic [1:0] check_mode;
  logic       q_full;
  logic       push;
  job_t       push_job;
  logic       pop;
  logic       head_valid;
  job_t       head;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode <= MODE_CONST;
    end else if (cfg_we) begin
      check_mode <= cfg_wdata;
    end
  end

  hfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_opcode  (s_axis_tuser),
    .in_command (s_axis_tdata[15:0]),
    .in_length  (s_axis_tdata[31:16]),
    .in_byte    (s_axis_tdata[39:32]),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  hfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  hfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .check_mode (check_mode),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_end    (m_axis_tlast)
  );

endmodule

// File: hw/rtl/hfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfe_front
// Accepts requests, tracks the open frame and turns requests into jobs.
// ----------------------------------------------------------------------------
module hfe_front import hfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [15:0] in_command,
  input  logic [15:0] in_length,
  input  logic [7:0]  in_byte,
  input  logic        q_full,
  output logic        push,
  output job_t        push_job
);

  logic        frame_open;
  logic        frame_open_next;
  logic [15:0] remaining;
  logic [15:0] remaining_next;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    frame_open_next = frame_open;
    remaining_next  = remaining;
    push            = 1'b0;
    push_job.is_start = !in_opcode;
    push_job.w1       = in_length;
    push_job.w0       = in_opcode ? {8'h00, in_byte} : in_command;
    push_job.close    = 1'b0;
    if (accept) begin
      if (!in_opcode) begin
        push            = 1'b1;
        push_job.close  = (in_length == 16'd0);
        frame_open_next = (in_length != 16'd0);
        remaining_next  = in_length;
      end else if (frame_open) begin
        // payload with no frame open is dropped
        push            = 1'b1;
        push_job.close  = (remaining == 16'd1);
        frame_open_next = (remaining != 16'd1);
        remaining_next  = remaining - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      remaining  <= 16'd0;
    end else begin
      frame_open <= frame_open_next;
      remaining  <= remaining_next;
    end
  end

endmodule

// File: hw/rtl/hfe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfe_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module hfe_queue import hfe_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/hfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfe_back
// Walks each job byte by byte, escapes, runs the checks and drives the output.
// ----------------------------------------------------------------------------
module hfe_back import hfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] check_mode,
  input  logic       head_valid,
  input  job_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_end
);

  logic        active, active_next;
  slot_t       slot, slot_next, slot_cur, slot_adv;
  logic        esc_pending, esc_pending_next;
  logic [15:0] crc, crc_next;
  logic [31:0] sum, sum_next;
  logic [7:0]  held, held_next;
  logic        odd, odd_next;
  logic [31:0] wsum;
  logic [15:0] chk;
  logic        out_valid_next;
  logic [7:0]  out_byte_next;
  logic        out_end_next;

  logic        is_calc, step, advance, needs_esc, esc_able, is_body;
  logic [7:0]  raw;
  logic [16:0] fold;
  logic [15:0] fsum;

  // word-sum finish, one 17-bit fold and one 16-bit add
  assign fold = {1'b0, wsum[31:16]} + {1'b0, wsum[15:0]};
  assign fsum = ~(fold[15:0] + {15'd0, fold[16]});

  always_comb begin
    slot_cur = active ? slot : (head.is_start ? SL_FLAG : SL_DATA);
    is_calc  = (slot_cur == SL_CALC1) || (slot_cur == SL_CALC2);
    step     = head_valid && (is_calc || !out_valid || out_ready);

    unique case (slot_cur)
      SL_CMD_HI: raw = head.w0[15:8];
      SL_CMD_LO: raw = head.w0[7:0];
      SL_LEN_HI: raw = head.w1[15:8];
      SL_LEN_LO: raw = head.w1[7:0];
      SL_DATA:   raw = head.w0[7:0];
      SL_CHK_HI: raw = chk[15:8];
      SL_CHK_LO: raw = chk[7:0];
      default:   raw = FLAG_BYTE;
    endcase

    is_body   = (slot_cur == SL_CMD_HI) || (slot_cur == SL_CMD_LO) ||
                (slot_cur == SL_LEN_HI) || (slot_cur == SL_LEN_LO) ||
                (slot_cur == SL_DATA);
    esc_able  = is_body || (slot_cur == SL_CHK_HI) || (slot_cur == SL_CHK_LO);
    needs_esc = esc_able && ((raw == ESC_BYTE) || (raw == FLAG_BYTE));
    advance   = step && (is_calc || esc_pending || !needs_esc);

    unique case (slot_cur)
      SL_FLAG:   slot_adv = SL_CMD_HI;
      SL_CMD_HI: slot_adv = SL_CMD_LO;
      SL_CMD_LO: slot_adv = SL_LEN_HI;
      SL_LEN_HI: slot_adv = SL_LEN_LO;
      SL_LEN_LO: slot_adv = SL_CALC1;
      SL_DATA:   slot_adv = SL_CALC1;
      SL_CALC1:  slot_adv = SL_CALC2;
      SL_CALC2:  slot_adv = SL_CHK_HI;
      SL_CHK_HI: slot_adv = SL_CHK_LO;
      SL_CHK_LO: slot_adv = SL_END;
      default:   slot_adv = SL_END;
    endcase

    active_next = active;
    slot_next   = slot;
    pop         = 1'b0;
    if (advance) begin
      if ((slot_cur == SL_END) ||
          (((slot_cur == SL_LEN_LO) || (slot_cur == SL_DATA)) && !head.close)) begin
        pop         = 1'b1;
        active_next = 1'b0;
      end else begin
        active_next = 1'b1;
        slot_next   = slot_adv;
      end
    end else if (step) begin
      // first half of an escape pair
      active_next = 1'b1;
      slot_next   = slot_cur;
    end

    esc_pending_next = esc_pending;
    out_valid_next   = out_valid && !out_ready;
    out_byte_next    = out_byte;
    out_end_next     = out_end;
    if (step && !is_calc) begin
      esc_pending_next = esc_pending ? 1'b0 : needs_esc;
      out_valid_next   = 1'b1;
      out_end_next     = (slot_cur == SL_END);
      if (esc_pending) begin
        out_byte_next = raw ^ ESC_XOR;
      end else if (needs_esc) begin
        out_byte_next = ESC_BYTE;
      end else begin
        out_byte_next = raw;
      end
    end

    crc_next  = crc;
    sum_next  = sum;
    held_next = held;
    odd_next  = odd;
    if (step && (slot_cur == SL_FLAG)) begin
      crc_next  = 16'd0;
      sum_next  = 32'd0;
      held_next = 8'd0;
      odd_next  = 1'b0;
    end else if (step && is_body && !esc_pending) begin
      crc_next = crc_byte(crc, raw);
      if (odd) begin
        sum_next = sum + {16'd0, raw, held};
        odd_next = 1'b0;
      end else begin
        held_next = raw;
        odd_next  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      slot        <= SL_FLAG;
      esc_pending <= 1'b0;
      out_valid   <= 1'b0;
      crc         <= 16'd0;
      sum         <= 32'd0;
      held        <= 8'd0;
      odd         <= 1'b0;
    end else begin
      active      <= active_next;
      slot        <= slot_next;
      esc_pending <= esc_pending_next;
      out_valid   <= out_valid_next;
      crc         <= crc_next;
      sum         <= sum_next;
      held        <= held_next;
      odd         <= odd_next;
    end
  end

  always_ff @(posedge clk) begin
    out_byte <= out_byte_next;
    out_end  <= out_end_next;
    if (step && (slot_cur == SL_CALC1)) begin
      wsum <= sum + (odd ? {24'd0, held} : 32'd0);
    end
    if (step && (slot_cur == SL_CALC2)) begin
      unique case (check_mode)
        MODE_CRC: chk <= crc;
        MODE_SUM: chk <= {fsum[7:0], fsum[15:8]};
        default:  chk <= CONST_CHECK;
      endcase
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-stuffed frame encoder. Start and payload
// requests go in on the input stream with random gaps, and the output stream
// is throttled at random. A scoreboard predicts every framed byte, escape and
// check word, and compares each output byte with the oldest one it predicted.
// The check mode is changed between phases and covers every value, the unused
// one and a change while a frame is still open.
// ----------------------------------------------------------------------------
module tb_top;
  import hfe_pkg::*;

  localparam logic       OP_START     = 1'b0;
  localparam logic       OP_PAYLOAD   = 1'b1;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         PHASE_ITEMS  = 30;
  localparam logic [1:0] PHASE_MODES [6] = '{MODE_SUM, MODE_CRC, MODE_CONST,
                                             MODE_UNUSED, MODE_SUM, MODE_CRC};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  // predicts the framed byte stream and checks the encoder output against it
  class frame_scoreboard;
    logic [1:0]   mode;
    bit           frame_active;
    logic [15:0]  remaining;
    logic [15:0]  crc;
    logic [31:0]  word_sum;
    logic [7:0]   low_byte;
    bit           odd;
    int           errors;
    stream_byte_t expected_bytes[$];

    function new();
      mode         = MODE_CONST;
      frame_active = 1'b0;
      remaining    = '0;
      crc          = '0;
      word_sum     = '0;
      low_byte     = '0;
      odd          = 1'b0;
      errors       = 0;
    endfunction

    function void push(logic [7:0] b, logic last);
      stream_byte_t e;
      e.data = b;
      e.last = last;
      expected_bytes.push_back(e);
    endfunction

    function void push_escaped(logic [7:0] b);
      if (b == ESC_BYTE || b == FLAG_BYTE) begin
        push(ESC_BYTE, 1'b0);
        push(b ^ ESC_XOR, 1'b0);
      end else begin
        push(b, 1'b0);
      end
    endfunction

    // both checks run on every byte; the mode only picks one at the end
    function void absorb(logic [7:0] b);
      logic top;
      crc = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        top = crc[15];
        crc = crc << 1;
        if (top) crc = crc ^ CRC_POLY;
      end
      if (odd) begin
        word_sum = word_sum + {16'h0000, b, low_byte};
        odd = 1'b0;
      end else begin
        low_byte = b;
        odd = 1'b1;
      end
    endfunction

    function logic [15:0] check_word();
      logic [31:0] s;
      logic [15:0] c;
      case (mode)
        MODE_CRC: return crc;
        MODE_SUM: begin
          s = word_sum;
          if (odd) s = s + {24'h0, low_byte};
          s = {16'h0000, s[31:16]} + {16'h0000, s[15:0]};
          c = ~(s[15:0] + s[31:16]);
          return {c[7:0], c[15:8]};
        end
        default: return CONST_CHECK;
      endcase
    endfunction

    function void close_frame();
      logic [15:0] c;
      c = check_word();
      push_escaped(c[15:8]);
      push_escaped(c[7:0]);
      push(FLAG_BYTE, 1'b1);
      frame_active = 1'b0;
      remaining = '0;
    endfunction

    // returns 0 when the request is dropped and causes no output
    function bit note_request(logic op, logic [15:0] cmd, logic [15:0] len, logic [7:0] db);
      logic [31:0] header;
      if (op == OP_START) begin
        crc          = '0;
        word_sum     = '0;
        low_byte     = '0;
        odd          = 1'b0;
        frame_active = 1'b1;
        remaining    = len;
        header       = {cmd, len};
        push(FLAG_BYTE, 1'b0);
        for (int k = 3; k >= 0; k--) begin
          absorb(header[8*k +: 8]);
          push_escaped(header[8*k +: 8]);
        end
        if (remaining == 0) close_frame();
        return 1'b1;
      end
      if (!frame_active) return 1'b0;
      absorb(db);
      push_escaped(db);
      remaining = remaining - 16'd1;
      if (remaining == 0) close_frame();
      return 1'b1;
    endfunction

    function void check_result(logic [7:0] data, logic last);
      stream_byte_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected output, expected nothing, got byte %h last %b",
                 $time, data, last);
        return;
      end
      want = expected_bytes.pop_front();
      if (want.data !== data) begin
        errors++;
        $display("%0t: output byte mismatch, expected %h, got %h", $time, want.data, data);
      end
      if (want.last !== last) begin
        errors++;
        $display("%0t: frame end mismatch, expected %b, got %b", $time, want.last, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // command[15:0], payload_length[31:16], data_byte[39:32]
  logic        s_axis_tuser;   // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // out_byte[7:0]
  logic        m_axis_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;

  frame_scoreboard sb = new();
  int              items_counted = 0;
  bit              tx_steady = 1'b0;
  bit              long_hold_pending = 1'b0;

  hdlc_frame_encoder_crc16_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // escape candidates show up far more often than at random
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return ESC_BYTE;
      1: return FLAG_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_request(input logic op, input logic [15:0] cmd, input logic [15:0] len,
                              input logic [7:0] db);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {db, len, cmd};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (sb.note_request(op, cmd, len, db)) items_counted++;
  endtask

  // fields a request does not use still carry random bits
  task automatic send_start(input logic [15:0] cmd, input logic [15:0] len);
    send_request(OP_START, cmd, len, 8'($urandom));
  endtask

  task automatic send_payload(input logic [7:0] db);
    send_request(OP_PAYLOAD, 16'($urandom), 16'($urandom), db);
  endtask

  // dropped payload requests never enter the queue; the drain catches stray output after the last byte
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.mode = m;
  endtask

  task automatic random_phase(input int budget);
    int goal;
    int len;
    int k;
    goal = items_counted + budget;
    while (items_counted < goal) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, 19);
      if (k < 15) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
        send_start({rand_byte(), rand_byte()}, 16'(len));
        repeat (len) send_payload(rand_byte());
      end else if (k < 18) begin
        // long frame cut short, the next start drops it
        len = $urandom_range(1, 4);
        send_start({rand_byte(), rand_byte()}, 16'($urandom_range(len + 1, 65535)));
        repeat (len) send_payload(rand_byte());
      end else begin
        // stray byte, dropped unless a cut frame is still open
        send_payload(rand_byte());
      end
    end
    tx_steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  // output side: steady runs, random stalls, and one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b0;
        repeat (1 + pick_gap()) @(posedge clk);
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_START;
    cfg_we        = 1'b0;
    cfg_wdata     = MODE_CONST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_mode(MODE_CRC);
    send_payload(8'hA5);
    send_start(16'h7E7D, 16'h0000);
    send_start(16'hFFFF, 16'h0003);
    send_payload(8'h7E);
    send_payload(8'h7D);
    send_payload(8'h00);
    send_start(16'h0000, 16'hFFFF);
    send_payload(8'hFF);
    send_start(16'h5A5A, 16'h7E7D);
    send_payload(8'h80);
    send_start(16'h1234, 16'h0002);
    send_payload(8'h55);
    send_payload(8'hAA);
    send_payload(8'h11);
    wait_idle();

    write_mode(MODE_SUM);
    send_start(16'h7D7E, 16'h0001);
    send_payload(8'h7E);
    send_start(16'hA5C3, 16'h0003);
    send_payload(8'h01);
    send_payload(8'h02);
    send_payload(8'h03);
    wait_idle();

    write_mode(MODE_CONST);
    send_start(16'hBEEF, 16'h0000);
    wait_idle();

    write_mode(MODE_UNUSED);
    send_start(16'h0102, 16'h0001);
    send_payload(8'hFE);
    wait_idle();

    // mode changes while the frame is open, the new one must be used
    write_mode(MODE_CRC);
    send_start(16'hC0DE, 16'h0002);
    send_payload(8'h33);
    wait_idle();
    write_mode(MODE_SUM);
    send_payload(8'h44);
    wait_idle();

    foreach (PHASE_MODES[p]) begin
      write_mode(PHASE_MODES[p]);
      if (p == 1) long_hold_pending = 1'b1;
      random_phase(PHASE_ITEMS);
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("** hdlc_frame_encoder_crc16_top: PASSED **");
    end else begin
      $display("** hdlc_frame_encoder_crc16_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("%0t: timeout", $time);
    $display("** hdlc_frame_encoder_crc16_top: FAILED **");
    $finish;
  end

endmodule
